/* rtl/lba_pkg.sv */
// Shared types and constants of the linear bump allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package lba_pkg;

  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 25;
  localparam int ALIGN_W = 4;
  localparam int PAD_W   = 12;

  // Input opcodes
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_RESIZE = 2'd1;
  localparam logic [1:0] OP_FREE   = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FOREIGN = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_LEN   = 2'd1;
  localparam logic [1:0] REG_ALIGN = 2'd2;

  localparam logic [ALIGN_W-1:0] ALIGN_MAX   = 4'd12;
  localparam logic [ALIGN_W-1:0] ALIGN_RESET = 4'd5;

  // Item classes decided by the front
  localparam logic [2:0] KIND_NOP     = 3'd0;
  localparam logic [2:0] KIND_FREE    = 3'd1;
  localparam logic [2:0] KIND_ALLOC   = 3'd2;
  localparam logic [2:0] KIND_FOREIGN = 3'd3;
  localparam logic [2:0] KIND_RESIZE  = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  usable;
    logic [PAD_W-1:0]  amask;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [LEN_W-1:0]  req;
    logic [ADDR_W-1:0] olda;
    logic [ADDR_W-1:0] olda_off;   // old address minus base
    logic [LEN_W-1:0]  copy_len;   // min(old size, request)
    logic              grow;       // request above old size
    logic [LEN_W-1:0]  grow_len;   // request minus old size
    logic [ADDR_W-1:0] base_olds;  // base plus old size
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic [ADDR_W-1:0] clear_start;
    logic [LEN_W-1:0]  clear_length;
    logic [LEN_W-1:0]  copy_length;
  } res_t;

endpackage

/* rtl/lba_front.sv */
// Front stage: accepts input items and classifies them against the configuration.
// Depends on lba_pkg.
`timescale 1ns / 1ps

module lba_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lba_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [lba_pkg::LEN_W-1:0]  in_request_size,
  input  logic [lba_pkg::LEN_W-1:0]  in_old_size,
  input  logic [lba_pkg::ADDR_W-1:0] in_old_address,
  output logic                       push_valid,
  input  logic                       push_ready,
  output lba_pkg::cmd_t              push_data
);
  import lba_pkg::*;

  logic  valid_r, valid_nxt;
  cmd_t  cmd_r, cmd_nxt;
  logic  accept;
  logic  in_arena;
  logic [ADDR_W:0] arena_end;

  assign in_stall   = valid_r & ~push_ready;
  assign accept     = in_valid & ~in_stall;
  assign push_valid = valid_r;
  assign push_data  = cmd_r;

  assign arena_end = {1'b0, cfg.base} + {{(ADDR_W + 1 - LEN_W){1'b0}}, cfg.usable};
  assign in_arena  = (in_old_address >= cfg.base) && ({1'b0, in_old_address} < arena_end);

  always_comb begin
    cmd_nxt.req       = in_request_size;
    cmd_nxt.olda      = in_old_address;
    cmd_nxt.olda_off  = in_old_address - cfg.base;
    cmd_nxt.grow      = in_request_size > in_old_size;
    cmd_nxt.copy_len  = cmd_nxt.grow ? in_old_size : in_request_size;
    cmd_nxt.grow_len  = in_request_size - in_old_size;
    cmd_nxt.base_olds = cfg.base + {{(ADDR_W - LEN_W){1'b0}}, in_old_size};
    case (in_opcode)
      OP_ALLOC:  cmd_nxt.kind = KIND_ALLOC;
      OP_RESIZE: begin
        if (in_old_address == '0 || in_old_size == '0) begin
          cmd_nxt.kind = KIND_ALLOC;
        end else if (!in_arena) begin
          cmd_nxt.kind = KIND_FOREIGN;
        end else begin
          cmd_nxt.kind = KIND_RESIZE;
        end
      end
      OP_FREE:   cmd_nxt.kind = KIND_FREE;
      default:   cmd_nxt.kind = KIND_NOP;
    endcase
  end

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

/* rtl/lba_queue.sv */
// Two-entry queue of classified items between front and back.
// Depends on lba_pkg.
`timescale 1ns / 1ps

module lba_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  lba_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lba_pkg::cmd_t pop_data
);
  import lba_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = count_r != 2'd2;
  assign pop_valid  = count_r != 2'd0;
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* rtl/lba_back.sv */
// Back stage: holds the arena offsets, carries out each item, registers the result.
// Depends on lba_pkg.
`timescale 1ns / 1ps

module lba_back (
  input  logic          clk,
  input  logic          rst_n,
  input  lba_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  lba_pkg::cmd_t pop_data,
  output logic          out_valid,
  input  logic          out_stall,
  output lba_pkg::res_t out_res
);
  import lba_pkg::*;

  logic [LEN_W-1:0] next_free_r, next_free_nxt;
  logic [LEN_W-1:0] last_block_r, last_block_nxt;
  logic             valid_r, valid_nxt;
  res_t             res_r, res_nxt;
  logic             fire;

  logic [PAD_W-1:0]  low_p, pad;
  logic [LEN_W:0]    off;
  logic [LEN_W+1:0]  end_a;
  logic              fit_a;
  logic [ADDR_W-1:0] addr_a;
  logic [LEN_W:0]    end_r;
  logic              fit_r;
  logic              in_place;

  assign pop_ready = ~valid_r | ~out_stall;
  assign fire      = pop_valid & pop_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Fresh allocation: pad the current end up to the alignment
  assign low_p  = cfg.base[PAD_W-1:0] + next_free_r[PAD_W-1:0];
  assign pad    = (~low_p + 1'b1) & cfg.amask;
  assign off    = {1'b0, next_free_r} + {{(LEN_W + 1 - PAD_W){1'b0}}, pad};
  assign end_a  = {1'b0, off} + {2'b00, pop_data.req};
  assign fit_a  = end_a <= {2'b00, cfg.usable};
  assign addr_a = cfg.base + {{(ADDR_W - LEN_W - 1){1'b0}}, off};

  // In-place resize of the most recent block
  assign in_place = pop_data.olda_off == {{(ADDR_W - LEN_W){1'b0}}, last_block_r};
  assign end_r    = {1'b0, last_block_r} + {1'b0, pop_data.req};
  assign fit_r    = end_r <= {1'b0, cfg.usable};

  always_comb begin
    next_free_nxt  = next_free_r;
    last_block_nxt = last_block_r;
    res_nxt        = '0;
    case (pop_data.kind)
      KIND_FREE: begin
        next_free_nxt  = '0;
        last_block_nxt = '0;
      end
      KIND_FOREIGN: res_nxt.status = ST_FOREIGN;
      KIND_ALLOC, KIND_RESIZE: begin
        if (pop_data.kind == KIND_RESIZE && in_place) begin
          if (fit_r) begin
            next_free_nxt         = end_r[LEN_W-1:0];
            res_nxt.status        = ST_OK;
            res_nxt.block_address = pop_data.olda;
            if (pop_data.grow) begin
              res_nxt.clear_start  = pop_data.base_olds
                                   + {{(ADDR_W - LEN_W){1'b0}}, last_block_r};
              res_nxt.clear_length = pop_data.grow_len;
            end
          end else begin
            res_nxt.status = ST_NOSPACE;
          end
        end else if (fit_a) begin
          last_block_nxt        = off[LEN_W-1:0];
          next_free_nxt         = end_a[LEN_W-1:0];
          res_nxt.status        = ST_OK;
          res_nxt.block_address = addr_a;
          res_nxt.clear_start   = (pop_data.req != '0) ? addr_a : '0;
          res_nxt.clear_length  = pop_data.req;
          if (pop_data.kind == KIND_RESIZE) begin
            res_nxt.copy_length = pop_data.copy_len;
          end
        end else begin
          res_nxt.status = ST_NOSPACE;
        end
      end
      default: res_nxt = '0;
    endcase
  end

  always_comb begin
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      next_free_r  <= '0;
      last_block_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (fire) begin
        next_free_r  <= next_free_nxt;
        last_block_r <= last_block_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* rtl/linear_bump_allocator.sv */
// Linear bump allocator: each item passes the front register, the two-entry queue and the back result register.
// Throughput one item per cycle while no stage stalls; set by the offset update in the back stage.
// Front stage, two-entry queue and output register stall independently.
// Synchronous active-low reset clears both offsets, all valid flags and the queue,
// and sets base 0, length 0, alignment log2 5.
`timescale 1ns / 1ps

module linear_bump_allocator #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write channel
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  // input items
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_opcode,
  input  logic [lba_pkg::LEN_W-1:0]  in_request_size,
  input  logic [lba_pkg::LEN_W-1:0]  in_old_size,
  input  logic [lba_pkg::ADDR_W-1:0] in_old_address,
  // result items
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [lba_pkg::ADDR_W-1:0] out_block_address,
  output logic [lba_pkg::ADDR_W-1:0] out_clear_start,
  output logic [lba_pkg::LEN_W-1:0]  out_clear_length,
  output logic [lba_pkg::LEN_W-1:0]  out_copy_length
);
  import lba_pkg::*;

  // Offsets above 2^OFFSET_BITS are not usable
  localparam logic [ADDR_W:0] OFFSET_LIMIT = (ADDR_W + 1)'(1) << OFFSET_BITS;

  logic [ADDR_W-1:0]  base_r;
  logic [LEN_W-1:0]   length_r;
  logic [ALIGN_W-1:0] align_r;
  logic [ALIGN_W-1:0] align_sat;
  logic [PAD_W:0]     align_span;
  logic               cfg_write;
  cfg_t               cfg;

  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_data, pop_data;
  res_t out_res;

  // Always take writes: the user must change configuration only while the block is idle; the block does not enforce it
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      length_r <= '0;
      align_r  <= ALIGN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE:  base_r   <= cfg_data;
        REG_LEN:   length_r <= cfg_data[LEN_W-1:0];
        REG_ALIGN: align_r  <= cfg_data[ALIGN_W-1:0];
        default:   ;  // drop writes beyond the register list
      endcase
    end
  end

  // Saturate alignment at 4 KiB and clip the length to the offset range
  assign align_sat  = (align_r > ALIGN_MAX) ? ALIGN_MAX : align_r;
  assign align_span = (PAD_W + 1)'(1) << align_sat;

  always_comb begin
    cfg.base  = base_r;
    cfg.amask = align_span[PAD_W-1:0] - 1'b1;
    if ({{(ADDR_W + 1 - LEN_W){1'b0}}, length_r} < OFFSET_LIMIT) begin
      cfg.usable = length_r;
    end else begin
      cfg.usable = OFFSET_LIMIT[LEN_W-1:0];
    end
  end

  // Front: accept and classify
  lba_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_request_size (in_request_size),
    .in_old_size     (in_old_size),
    .in_old_address  (in_old_address),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_data       (push_data)
  );

  // Queue: decouple front stalls from back stalls
  lba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: update offsets and register the result
  lba_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_block_address = out_res.block_address;
  assign out_clear_start   = out_res.clear_start;
  assign out_clear_length  = out_res.clear_length;
  assign out_copy_length   = out_res.copy_length;

endmodule
